// ===== design/btnlpr_pkg.sv =====
// ----------------------------------------------------------------------------
// btnlpr_pkg
// Shared types and constants for the button long-press / auto-repeat block.
// ----------------------------------------------------------------------------
package btnlpr_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int TIME_BITS    = 16;

    // Widths of the configuration fields and item fields
    localparam int MODE_FIELD_W = 2;
    localparam int TIME_FIELD_W = 16;
    localparam int PIN_W        = 4;
    localparam int IDX_W        = 2;
    localparam int OPC_W        = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 5;
    localparam int MODES_W      = 8;

    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_TICK        = 3'd0,
        OP_RD_PRESSED  = 3'd1,
        OP_RD_RELEASED = 3'd2,
        OP_RD_TAP      = 3'd3,
        OP_RD_LONG     = 3'd4
    } op_t;

    typedef enum logic [MODE_FIELD_W-1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_LONG    = 2'd1,
        MODE_REPEAT  = 2'd2,
        MODE_PLAIN_B = 2'd3
    } mode_t;

    // Register word indexes (byte address is 8 * index)
    localparam logic [1:0] REG_MODES   = 2'd0;
    localparam logic [1:0] REG_LONG_T  = 2'd1;
    localparam logic [1:0] REG_REPEAT_T = 2'd2;

    typedef struct packed {
        logic [MODES_W-1:0]    modes;
        logic [CFG_DATA_W-1:0] long_times;
        logic [CFG_DATA_W-1:0] repeat_times;
    } btnlpr_cfg_t;

    // Latched event flags of one button, also used as a clear mask
    typedef struct packed {
        logic pressed;
        logic released;
        logic tap;
        logic lng;
    } btnlpr_flags_t;

endpackage

// ===== design/btnlpr_ifs.sv =====
// ----------------------------------------------------------------------------
// btnlpr_ifs
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface btnlpr_req_if;
    import btnlpr_pkg::*;

    logic             valid;
    logic             ready;
    logic [OPC_W-1:0] opcode;
    logic [PIN_W-1:0] pin_levels;
    logic [IDX_W-1:0] button_index;

    modport source (output valid, output opcode, output pin_levels,
                    output button_index, input ready);
    modport sink   (input valid, input opcode, input pin_levels,
                    input button_index, output ready);
endinterface

interface btnlpr_rsp_if;
    logic valid;
    logic ready;
    logic event_flag;

    modport source (output valid, output event_flag, input ready);
    modport sink   (input valid, input event_flag, output ready);
endinterface

// ===== design/btnlpr_cfg.sv =====
// ----------------------------------------------------------------------------
// btnlpr_cfg
// APB register file: button modes, long-press times, repeat times.
// ----------------------------------------------------------------------------
module btnlpr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btnlpr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [btnlpr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [btnlpr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready,
    output btnlpr_pkg::btnlpr_cfg_t             cfg
);
    import btnlpr_pkg::*;

    logic [MODES_W-1:0]    modes_reg;
    logic [CFG_DATA_W-1:0] long_reg;
    logic [CFG_DATA_W-1:0] repeat_reg;
    logic                  wr_en;
    logic [1:0]            word_sel;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign word_sel = paddr[CFG_ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg  <= '0;
            long_reg   <= '0;
            repeat_reg <= '0;
        end
        else if (wr_en)
        begin
            case (word_sel)
                REG_MODES:    modes_reg  <= pwdata[MODES_W-1:0];
                REG_LONG_T:   long_reg   <= pwdata;
                REG_REPEAT_T: repeat_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (word_sel)
            REG_MODES:    prdata = {{(CFG_DATA_W-MODES_W){1'b0}}, modes_reg};
            REG_LONG_T:   prdata = long_reg;
            REG_REPEAT_T: prdata = repeat_reg;
            default:      prdata = '0;
        endcase
    end

    assign cfg.modes        = modes_reg;
    assign cfg.long_times   = long_reg;
    assign cfg.repeat_times = repeat_reg;

endmodule

// ===== design/btnlpr_lane.sv =====
// ----------------------------------------------------------------------------
// btnlpr_lane
// One button: hold counter, debounce-free edge tracking and event flags.
// ----------------------------------------------------------------------------
module btnlpr_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              tick_en,
    input  logic                              down,
    input  btnlpr_pkg::mode_t                 mode,
    input  logic [btnlpr_pkg::TIME_BITS-1:0]  long_time,
    input  logic [btnlpr_pkg::TIME_BITS-1:0]  repeat_time,
    input  btnlpr_pkg::btnlpr_flags_t         clr,
    output btnlpr_pkg::btnlpr_flags_t         flags
);
    import btnlpr_pkg::*;

    logic [TIME_BITS-1:0] hold_reg, hold_next;
    logic                 was_down_reg, was_down_next;
    btnlpr_flags_t        flags_reg, flags_next;
    logic [TIME_BITS-1:0] count_up;
    logic                 counting;
    logic                 long_hit;
    logic                 repeat_hit;

    assign counting = (mode == MODE_LONG) || (mode == MODE_REPEAT);

    always_comb
    begin
        // saturating increment
        if (counting && (hold_reg != TIME_MAX))
            count_up = hold_reg + 1'b1;
        else
            count_up = hold_reg;
        long_hit   = (mode == MODE_LONG) && (long_time != '0) && (count_up == long_time);
        repeat_hit = (mode == MODE_REPEAT) && (repeat_time != '0)
                     && (count_up == repeat_time);
    end

    always_comb
    begin
        hold_next     = hold_reg;
        was_down_next = was_down_reg;
        flags_next    = flags_reg;
        if (tick_en)
        begin
            if (was_down_reg && !down)
            begin
                flags_next.tap      = (hold_reg < long_time);
                flags_next.released = 1'b1;
                flags_next.pressed  = 1'b0;
                hold_next           = '0;
                was_down_next       = 1'b0;
            end
            else if (down)
            begin
                if (long_hit)
                begin
                    flags_next.lng = 1'b1;
                    hold_next      = count_up;
                end
                else if (repeat_hit)
                begin
                    flags_next.pressed = 1'b1;
                    hold_next          = '0;
                end
                else
                begin
                    hold_next = count_up;
                    if (!was_down_reg)
                    begin
                        flags_next.released = 1'b0;
                        flags_next.pressed  = 1'b1;
                        was_down_next       = 1'b1;
                    end
                end
            end
        end
        else
        begin
            flags_next = flags_reg & ~clr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= '0;
            was_down_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            hold_reg     <= hold_next;
            was_down_reg <= was_down_next;
            flags_reg    <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

// ===== design/button_press_tap_longpress_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_press_tap_longpress_repeat_unit
// Button event block with tap, long-press and auto-repeat detection.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one beat per item: a tick (opcode 0) samples all active-low
//   pins in pin_levels and advances every button's hold counter and event
//   flags; a read (opcodes 1..4) returns one flag of button_index on rsp and
//   clears it. Reading a set long-press flag makes the next released read
//   return 0 once. Opcodes 5..7 are dropped silently.
//   Configuration is written over APB at byte addresses 0 (modes), 8 (long
//   times) and 16 (repeat times), 64-bit data, pready tied high.
// Timing:
//   A beat lands in the input register, is worked against the per-button
//   lanes, and a read result is registered in the output stage, which drives
//   rsp valid. One item per cycle is sustained while rsp is not stalled.
// Reset:
//   rst_n clears all counters, flags, the suppression bit, configuration and
//   both pipeline stages.
// Stall:
//   While rsp is stalled the held result stays put; ticks still advance, and
//   a read waits in the input register, so req ready drops only then.
// ----------------------------------------------------------------------------
module button_press_tap_longpress_repeat_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btnlpr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [btnlpr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [btnlpr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready,
    btnlpr_req_if.sink                          req,
    btnlpr_rsp_if.source                        rsp
);
    import btnlpr_pkg::*;

    btnlpr_cfg_t cfg;

    // input stage
    logic             in_vld_reg;
    logic [OPC_W-1:0] in_op_reg;
    logic [PIN_W-1:0] in_pins_reg;
    logic [IDX_W-1:0] in_idx_reg;

    // output stage
    logic out_vld_reg, out_vld_next;
    logic out_flag_reg, out_flag_next;

    logic suppress_reg, suppress_next;

    logic          advance;
    logic          has_result;
    logic          is_tick;
    logic          in_take;
    btnlpr_flags_t sel_flags;
    btnlpr_flags_t lane_flags [BUTTON_COUNT];
    btnlpr_flags_t lane_clr   [BUTTON_COUNT];
    btnlpr_flags_t clr_mask;
    logic          lane_hit   [BUTTON_COUNT];

    btnlpr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Classify the held item. A read needs a free output slot, a tick or an
    // unknown opcode never does.
    always_comb
    begin
        is_tick    = 1'b0;
        has_result = 1'b0;
        case (op_t'(in_op_reg))
            OP_TICK:        is_tick    = 1'b1;
            OP_RD_PRESSED,
            OP_RD_RELEASED,
            OP_RD_TAP,
            OP_RD_LONG:     has_result = 1'b1;
            default:        ;
        endcase
    end

    assign advance   = in_vld_reg && (!has_result || !out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign in_take   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (req.ready)
            in_vld_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= req.opcode;
            in_pins_reg <= req.pin_levels;
            in_idx_reg  <= req.button_index;
        end
    end

    // Gather the flags of the addressed button; an index with no button
    // matches nothing and reads as zero.
    always_comb
    begin
        sel_flags = '0;
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            lane_hit[b] = ({{(32-IDX_W){1'b0}}, in_idx_reg} == 32'(b));
            if (lane_hit[b])
                sel_flags = sel_flags | lane_flags[b];
        end
    end

    // Read decode: result value, clear mask and suppression update.
    always_comb
    begin
        out_flag_next = out_flag_reg;
        clr_mask      = '0;
        suppress_next = suppress_reg;
        if (advance && has_result)
        begin
            case (op_t'(in_op_reg))
                OP_RD_PRESSED:
                begin
                    out_flag_next    = sel_flags.pressed;
                    clr_mask.pressed = 1'b1;
                end
                OP_RD_RELEASED:
                begin
                    // a pending suppression eats this read, flag untouched
                    if (suppress_reg)
                    begin
                        out_flag_next = 1'b0;
                        suppress_next = 1'b0;
                    end
                    else
                    begin
                        out_flag_next     = sel_flags.released;
                        clr_mask.released = 1'b1;
                    end
                end
                OP_RD_TAP:
                begin
                    out_flag_next = sel_flags.tap;
                    clr_mask.tap  = 1'b1;
                end
                OP_RD_LONG:
                begin
                    out_flag_next = sel_flags.lng;
                    clr_mask.lng  = 1'b1;
                    if (sel_flags.lng)
                        suppress_next = 1'b1;
                end
                default: ;
            endcase
        end
    end

    genvar gb;
    generate
        for (gb = 0; gb < BUTTON_COUNT; gb++)
        begin : g_lane
            mode_t                mode_b;
            logic [TIME_BITS-1:0] long_b;
            logic [TIME_BITS-1:0] rep_b;
            logic                 down_b;

            if (gb < 4)
            begin : g_wired
                assign mode_b = mode_t'(cfg.modes[MODE_FIELD_W*gb +: MODE_FIELD_W]);
                assign long_b = cfg.long_times[TIME_FIELD_W*gb +: TIME_BITS];
                assign rep_b  = cfg.repeat_times[TIME_FIELD_W*gb +: TIME_BITS];
                assign down_b = !in_pins_reg[gb];
            end
            else
            begin : g_absent
                assign mode_b = MODE_PLAIN;
                assign long_b = '0;
                assign rep_b  = '0;
                assign down_b = 1'b0;
            end

            assign lane_clr[gb] = lane_hit[gb] ? clr_mask : '0;

            btnlpr_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .tick_en     (advance && is_tick),
                .down        (down_b),
                .mode        (mode_b),
                .long_time   (long_b),
                .repeat_time (rep_b),
                .clr         (lane_clr[gb]),
                .flags       (lane_flags[gb])
            );
        end
    endgenerate

    always_comb
    begin
        if (advance && has_result)
            out_vld_next = 1'b1;
        else if (rsp.ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            suppress_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            suppress_reg <= suppress_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flag_reg <= out_flag_next;
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.event_flag = out_flag_reg;

    // A tick leaves the output stage alone.
    a_tick_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_tick |=> out_vld_reg == $past(out_vld_reg && !rsp.ready))
        else $error("tick produced a result beat");

    // Every read that advances shows up in the output stage.
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result |=> out_vld_reg)
        else $error("read item lost its result");

    // Only a long read can arm the suppression.
    a_suppress_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(suppress_reg) |-> $past(advance && (in_op_reg == OP_RD_LONG)))
        else $error("suppression armed by a non-long read");

    // A suppressed released read returns zero.
    a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_RD_RELEASED) && suppress_reg |=> !out_flag_reg)
        else $error("suppressed released read returned one");

endmodule
